/* sv/sps_pkg.sv */
// ============================================================================
// sps_pkg: shared types, constants and phase tables for the stepper sequencer
// Holds the request opcodes, the step modes, the controller-to-datapath
// command bundle and the coil pattern lookups.
// ============================================================================
package sps_pkg;

    // Width of the step counter; it equals the step total width, so all bits are used
    localparam int STEP_COUNT_BITS = 20;

    // Fixed field widths
    localparam int TOTAL_W  = 20;
    localparam int RPM_W    = 10;
    localparam int PERIOD_W = 14;
    localparam int PHASE_W  = 3;
    localparam int COIL_W   = 4;
    localparam int OP_W     = 2;
    localparam int MODE_W   = 2;

    // Microseconds per minute over steps per revolution
    localparam int US_PER_MINUTE   = 60000000;
    localparam int STEPS_PER_REV   = 4096;
    localparam int PERIOD_DIVIDEND = US_PER_MINUTE / STEPS_PER_REV;

    // Divider iteration counter
    localparam int DIV_CNT_W = $clog2(PERIOD_W);

    // Request opcodes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

    // Step modes
    localparam logic [MODE_W-1:0] MODE_HALF = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FULL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WAVE = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_start;   // latch start fields, seed the divider
        logic div_step;     // one restoring-division iteration
        logic apply_start;  // commit the new move
        logic apply_tick;   // one microsecond tick
        logic apply_stop;   // drop all coils
    } sps_cmd_t;

    // Last valid phase index for a mode
    function automatic logic [PHASE_W-1:0] mode_last(input logic [MODE_W-1:0] mode);
        logic [PHASE_W-1:0] last;
        begin
            if (mode == MODE_FULL || mode == MODE_WAVE)
                last = 3'd3;
            else
                last = 3'd7;
            return last;
        end
    endfunction

    // Coil pattern for a mode and phase index
    function automatic logic [COIL_W-1:0] coil_pattern(input logic [MODE_W-1:0] mode,
                                                       input logic [PHASE_W-1:0] idx);
        logic [COIL_W-1:0] pat;
        begin
            pat = '0;
            if (mode == MODE_FULL) begin
                case (idx[1:0])
                    2'd0:    pat = 4'h3;
                    2'd1:    pat = 4'h6;
                    2'd2:    pat = 4'hC;
                    default: pat = 4'h9;
                endcase
            end else if (mode == MODE_WAVE) begin
                case (idx[1:0])
                    2'd0:    pat = 4'h1;
                    2'd1:    pat = 4'h2;
                    2'd2:    pat = 4'h4;
                    default: pat = 4'h8;
                endcase
            end else begin
                case (idx)
                    3'd0:    pat = 4'h1;
                    3'd1:    pat = 4'h3;
                    3'd2:    pat = 4'h2;
                    3'd3:    pat = 4'h6;
                    3'd4:    pat = 4'h4;
                    3'd5:    pat = 4'hC;
                    3'd6:    pat = 4'h8;
                    default: pat = 4'h9;
                endcase
            end
            return pat;
        end
    endfunction

endpackage

/* sv/stepper_phase_sequencer_unit.sv */
// ============================================================================
// stepper_phase_sequencer_unit: four-coil stepper phase sequencer
// Walks half-step, full-step or wave phase tables on microsecond ticks.
// ============================================================================
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  in      | in_valid/in_ready, opcode, step_total,               | into block
//          | counter_clockwise, step_mode, speed_rpm              |
//  out     | out_valid/out_ready, coils, busy_res, phase          | from block
//
//  Tick, stop and unknown requests post a result in the cycle after acceptance.
//  A start latches its fields, runs 14 iterations of the restoring divider
//  that forms the step period, and then commits the move.
//  A new request is taken in the cycle its predecessor's result is taken.
//  While a result waits for out_ready, no new request is taken.
//  Reset clears the move state: coils low, idle, phase 0, half-step mode.
//
module stepper_phase_sequencer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sps_pkg::OP_W-1:0]        opcode,
    input  logic [sps_pkg::TOTAL_W-1:0]     step_total,
    input  logic                            counter_clockwise,
    input  logic [sps_pkg::MODE_W-1:0]      step_mode,
    input  logic [sps_pkg::RPM_W-1:0]       speed_rpm,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sps_pkg::COIL_W-1:0]      coils,
    output logic                            busy_res,
    output logic [sps_pkg::PHASE_W-1:0]     phase
);

    sps_pkg::sps_cmd_t cmd;

    // Request sequencing
    sps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Divider and move state
    sps_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .step_total        (step_total),
        .counter_clockwise (counter_clockwise),
        .step_mode         (step_mode),
        .speed_rpm         (speed_rpm),
        .coils             (coils),
        .busy_res          (busy_res),
        .phase             (phase)
    );

endmodule

/* sv/sps_ctrl.sv */
// ============================================================================
// sps_ctrl: request sequencing for the stepper sequencer
// Accepts requests, runs the period divider for a start, and owns the
// result valid flag.
// ============================================================================
module sps_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sps_pkg::OP_W-1:0]      opcode,
    output logic                          out_valid,
    input  logic                          out_ready,
    output sps_pkg::sps_cmd_t             cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } state_t;

    state_t                          state_reg, state_next;
    logic [sps_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            accept;

    // Take a request only when idle and the result slot is free or freeing
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Decode state and opcode into datapath commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    unique case (opcode)
                        sps_pkg::OP_TICK:
                        begin
                            cmd.apply_tick = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        sps_pkg::OP_STOP:
                        begin
                            cmd.apply_stop = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        sps_pkg::OP_START:
                        begin
                            cmd.load_start = 1'b1;
                            cnt_next       = '0;
                            state_next     = S_DIV;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == sps_pkg::DIV_CNT_W'(sps_pkg::PERIOD_W - 1))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.apply_start = 1'b1;
                out_valid_next  = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Requests are only taken from idle
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("request taken outside idle");

    // No result is pending while the divider runs
    a_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> !out_valid_reg)
        else $error("result pending during division");

    // A finished start always posts a result
    a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN |=> out_valid_reg)
        else $error("start finished without a result");

    // A start leads into the divider
    a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_start |=> state_reg == S_DIV)
        else $error("start did not enter division");

endmodule

/* sv/sps_dp.sv */
// ============================================================================
// sps_dp: datapath of the stepper sequencer
// Restoring divider for the step period, move state and phase walking.
// The move state registers drive the result ports directly.
// ============================================================================
module sps_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sps_pkg::sps_cmd_t               cmd,
    input  logic [sps_pkg::TOTAL_W-1:0]     step_total,
    input  logic                            counter_clockwise,
    input  logic [sps_pkg::MODE_W-1:0]      step_mode,
    input  logic [sps_pkg::RPM_W-1:0]       speed_rpm,
    output logic [sps_pkg::COIL_W-1:0]      coils,
    output logic                            busy_res,
    output logic [sps_pkg::PHASE_W-1:0]     phase
);

    localparam int PW = sps_pkg::PERIOD_W;
    localparam int RW = sps_pkg::RPM_W;
    localparam int SW = sps_pkg::STEP_COUNT_BITS;

    // Start latch and divider
    logic [SW-1:0]                   total_reg;
    logic                            upward_reg;
    logic [sps_pkg::MODE_W-1:0]      mode_reg;
    logic [RW-1:0]                   div_reg;
    logic [RW-1:0]                   rem_reg, rem_next;
    logic [PW-1:0]                   quo_reg, quo_next;
    logic [RW:0]                     shifted;
    logic [RW+1:0]                   diff;

    // Move state
    logic [sps_pkg::PHASE_W-1:0]     phase_reg, phase_next;
    logic [SW-1:0]                   steps_reg, steps_next;
    logic [PW-1:0]                   delay_reg, delay_next;
    logic [PW-1:0]                   period_reg, period_next;
    logic [sps_pkg::MODE_W-1:0]      amode_reg, amode_next;
    logic                            walk_up_reg, walk_up_next;
    logic                            running_reg, running_next;
    logic [sps_pkg::COIL_W-1:0]      coil_reg, coil_next;

    logic [sps_pkg::PHASE_W-1:0]     start_phase;
    logic [sps_pkg::PHASE_W-1:0]     adv_phase;
    logic [sps_pkg::PHASE_W-1:0]     last_idx;

    // One restoring division step
    assign shifted = {rem_reg, quo_reg[PW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, div_reg};

    always_comb
    begin
        if (!diff[RW+1])
            rem_next = diff[RW-1:0];
        else
            rem_next = shifted[RW-1:0];
        quo_next = {quo_reg[PW-2:0], ~diff[RW+1]};
    end

    // Latch start fields and run the divider
    always_ff @(posedge clk)
    begin
        if (cmd.load_start) begin
            total_reg  <= SW'(step_total);
            upward_reg <= counter_clockwise;
            mode_reg   <= (step_mode == sps_pkg::MODE_FULL ||
                           step_mode == sps_pkg::MODE_WAVE) ? step_mode : sps_pkg::MODE_HALF;
            div_reg    <= (speed_rpm == '0) ? RW'(1) : speed_rpm;
            rem_reg    <= '0;
            quo_reg    <= PW'(sps_pkg::PERIOD_DIVIDEND);
        end else if (cmd.div_step) begin
            rem_reg    <= rem_next;
            quo_reg    <= quo_next;
        end
    end

    // Phase stepping for the active move
    assign last_idx    = sps_pkg::mode_last(amode_reg);
    assign start_phase = upward_reg ? '0 : sps_pkg::mode_last(mode_reg);

    always_comb
    begin
        if (walk_up_reg)
            adv_phase = (phase_reg >= last_idx) ? '0 : phase_reg + 1'b1;
        else
            adv_phase = (phase_reg == '0 || phase_reg > last_idx) ? last_idx
                                                                  : phase_reg - 1'b1;
    end

    // Update the move state per command
    always_comb
    begin
        phase_next   = phase_reg;
        steps_next   = steps_reg;
        delay_next   = delay_reg;
        period_next  = period_reg;
        amode_next   = amode_reg;
        walk_up_next = walk_up_reg;
        running_next = running_reg;
        coil_next    = coil_reg;
        if (cmd.apply_start) begin
            amode_next   = mode_reg;
            walk_up_next = upward_reg;
            period_next  = quo_reg;
            phase_next   = start_phase;
            if (total_reg == '0) begin
                coil_next    = '0;
                running_next = 1'b0;
                steps_next   = '0;
                delay_next   = '0;
            end else begin
                coil_next    = sps_pkg::coil_pattern(mode_reg, start_phase);
                steps_next   = total_reg - 1'b1;
                delay_next   = quo_reg;
                running_next = 1'b1;
            end
        end else if (cmd.apply_stop) begin
            coil_next    = '0;
            running_next = 1'b0;
            steps_next   = '0;
            delay_next   = '0;
        end else if (cmd.apply_tick && running_reg) begin
            if (delay_reg > PW'(1)) begin
                delay_next = delay_reg - 1'b1;
            end else if (steps_reg == '0) begin
                coil_next    = '0;
                running_next = 1'b0;
                steps_next   = '0;
                delay_next   = '0;
            end else begin
                phase_next = adv_phase;
                coil_next  = sps_pkg::coil_pattern(amode_reg, adv_phase);
                steps_next = steps_reg - 1'b1;
                delay_next = period_reg;
            end
        end
    end

    // Hold the move state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= '0;
            steps_reg   <= '0;
            delay_reg   <= '0;
            period_reg  <= '0;
            amode_reg   <= sps_pkg::MODE_HALF;
            walk_up_reg <= 1'b0;
            running_reg <= 1'b0;
            coil_reg    <= '0;
        end else begin
            phase_reg   <= phase_next;
            steps_reg   <= steps_next;
            delay_reg   <= delay_next;
            period_reg  <= period_next;
            amode_reg   <= amode_next;
            walk_up_reg <= walk_up_next;
            running_reg <= running_next;
            coil_reg    <= coil_next;
        end
    end

    assign coils    = coil_reg;
    assign busy_res = running_reg;
    assign phase    = phase_reg;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ============================================================================
// testbench: self-checking bench for the stepper phase sequencer
// Runs a directed table of requests, then random move sequences, through the
// valid/ready channels with random idling on both sides. Each result is held
// to its table row or an in-bench model of phase tables, step timer and moves.
// ============================================================================
module testbench;

    // Opcode three and mode three carry no name in the package
    localparam logic [sps_pkg::OP_W-1:0]   OP_RESERVED  = 2'd3;
    localparam logic [sps_pkg::MODE_W-1:0] MODE_UNKNOWN = 2'd3;

    localparam int RANDOM_REQUESTS = 1600;
    localparam int PRESSURE_POINT  = 800;
    localparam int DRAIN_CYCLES    = 24;

    // Coil patterns per phase, bit0 is the first coil
    localparam logic [sps_pkg::COIL_W-1:0] HALF_COILS [8] = '{4'h1, 4'h3, 4'h2, 4'h6,
                                                              4'h4, 4'hC, 4'h8, 4'h9};
    localparam logic [sps_pkg::COIL_W-1:0] FULL_COILS [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
    localparam logic [sps_pkg::COIL_W-1:0] WAVE_COILS [4] = '{4'h1, 4'h2, 4'h4, 4'h8};

    typedef struct packed {
        logic [sps_pkg::OP_W-1:0]    op;
        logic [sps_pkg::TOTAL_W-1:0] total;
        logic                        ccw;
        logic [sps_pkg::MODE_W-1:0]  mode;
        logic [sps_pkg::RPM_W-1:0]   rpm;
    } motor_req_t;

    typedef struct packed {
        logic [sps_pkg::COIL_W-1:0]  coils;
        logic                        busy;
        logic [sps_pkg::PHASE_W-1:0] phase;
    } coil_state_t;

    typedef struct packed {
        motor_req_t  req;
        logic        typed;
        coil_state_t want;
    } stim_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [sps_pkg::OP_W-1:0]     opcode;
    logic [sps_pkg::TOTAL_W-1:0]  step_total;
    logic                         counter_clockwise;
    logic [sps_pkg::MODE_W-1:0]   step_mode;
    logic [sps_pkg::RPM_W-1:0]    speed_rpm;
    logic                         out_valid;
    logic                         out_ready;
    logic [sps_pkg::COIL_W-1:0]   coils;
    logic                         busy_res;
    logic [sps_pkg::PHASE_W-1:0]  phase;

    // Model state of the sequencer
    logic [sps_pkg::PHASE_W-1:0]          pos_idx;
    logic [sps_pkg::STEP_COUNT_BITS-1:0]  steps_remaining;
    logic [sps_pkg::PERIOD_W-1:0]         ticks_to_next;
    logic [sps_pkg::PERIOD_W-1:0]         period_ticks;
    logic [sps_pkg::MODE_W-1:0]           cur_mode;
    logic                                 upward;
    logic                                 moving;
    logic [sps_pkg::COIL_W-1:0]           coil_drive;

    coil_state_t expected_coils [$];
    stim_row_t   directed_rows [$];

    int error_count;
    int accepted_count;
    int counted_requests;
    int start_count;
    int stop_count;
    int tick_count;
    int advance_count;
    int completed_moves;
    int burst_left;

    stepper_phase_sequencer_unit DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .opcode            (opcode),
        .step_total        (step_total),
        .counter_clockwise (counter_clockwise),
        .step_mode         (step_mode),
        .speed_rpm         (speed_rpm),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .coils             (coils),
        .busy_res          (busy_res),
        .phase             (phase)
    );

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("Timeout: %0d results still pending", expected_coils.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    function automatic logic [sps_pkg::COIL_W-1:0] phase_coils(
        input logic [sps_pkg::MODE_W-1:0] mode,
        input logic [sps_pkg::PHASE_W-1:0] idx);
        if (mode == sps_pkg::MODE_FULL)
            return FULL_COILS[idx[1:0]];
        if (mode == sps_pkg::MODE_WAVE)
            return WAVE_COILS[idx[1:0]];
        return HALF_COILS[idx];
    endfunction

    function automatic logic [sps_pkg::PHASE_W-1:0] last_phase(
        input logic [sps_pkg::MODE_W-1:0] mode);
        return (mode == sps_pkg::MODE_FULL || mode == sps_pkg::MODE_WAVE) ? 3'd3 : 3'd7;
    endfunction

    // Drop all coils and end the move
    function automatic void halt_motion();
        coil_drive      = '0;
        moving          = 1'b0;
        steps_remaining = '0;
        ticks_to_next   = '0;
    endfunction

    // Apply one request to the model and return the coil state after it
    function automatic coil_state_t advance_sequencer(input motor_req_t r);
        logic [sps_pkg::RPM_W-1:0]   eff_rpm;
        logic [sps_pkg::PHASE_W-1:0] last;
        coil_state_t                 res;

        case (r.op)
            sps_pkg::OP_START:
            begin
                start_count++;
                eff_rpm      = (r.rpm == '0) ? sps_pkg::RPM_W'(1) : r.rpm;
                cur_mode     = (r.mode == MODE_UNKNOWN) ? sps_pkg::MODE_HALF : r.mode;
                upward       = r.ccw;
                period_ticks = sps_pkg::PERIOD_W'(sps_pkg::PERIOD_DIVIDEND / int'(eff_rpm));
                last         = last_phase(cur_mode);
                pos_idx      = r.ccw ? '0 : last;
                if (r.total[sps_pkg::STEP_COUNT_BITS-1:0] == '0)
                    halt_motion();
                else
                begin
                    coil_drive      = phase_coils(cur_mode, pos_idx);
                    steps_remaining = r.total[sps_pkg::STEP_COUNT_BITS-1:0] - 1'b1;
                    ticks_to_next   = period_ticks;
                    moving          = 1'b1;
                end
            end
            sps_pkg::OP_STOP:
            begin
                stop_count++;
                halt_motion();
            end
            sps_pkg::OP_TICK:
            begin
                tick_count++;
                if (moving)
                begin
                    last = last_phase(cur_mode);
                    if (ticks_to_next > 1)
                        ticks_to_next--;
                    else if (steps_remaining == '0)
                    begin
                        halt_motion();
                        completed_moves++;
                    end
                    else
                    begin
                        // Step to the neighbor phase, wrapping at the table ends
                        if (upward)
                            pos_idx = (pos_idx >= last) ? '0 : pos_idx + 1'b1;
                        else
                            pos_idx = (pos_idx == '0 || pos_idx > last) ? last : pos_idx - 1'b1;
                        coil_drive = phase_coils(cur_mode, pos_idx);
                        steps_remaining--;
                        ticks_to_next = period_ticks;
                        advance_count++;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.coils = coil_drive;
        res.busy  = moving;
        res.phase = pos_idx;
        return res;
    endfunction

    function automatic motor_req_t random_request();
        motor_req_t r;
        r.op    = sps_pkg::OP_W'($urandom_range(0, 3));
        r.total = sps_pkg::TOTAL_W'($urandom);
        r.ccw   = 1'($urandom);
        r.mode  = sps_pkg::MODE_W'($urandom_range(0, 3));
        r.rpm   = sps_pkg::RPM_W'($urandom);
        return r;
    endfunction

    function automatic motor_req_t make_request(input logic [sps_pkg::OP_W-1:0] op,
                                                input logic [sps_pkg::TOTAL_W-1:0] total,
                                                input logic ccw,
                                                input logic [sps_pkg::MODE_W-1:0] mode,
                                                input logic [sps_pkg::RPM_W-1:0] rpm);
        motor_req_t r;
        r.op    = op;
        r.total = total;
        r.ccw   = ccw;
        r.mode  = mode;
        r.rpm   = rpm;
        return r;
    endfunction

    function automatic stim_row_t make_row(input motor_req_t r, input logic typed,
                                           input logic [sps_pkg::COIL_W-1:0] c,
                                           input logic b,
                                           input logic [sps_pkg::PHASE_W-1:0] p);
        stim_row_t row;
        row.req        = r;
        row.typed      = typed;
        row.want.coils = c;
        row.want.busy  = b;
        row.want.phase = p;
        return row;
    endfunction

    // Present one request, hold it until taken, then record the expected result
    task automatic send_request(input motor_req_t r, input logic typed,
                                input coil_state_t want);
        int          gap;
        logic        was_moving;
        coil_state_t predicted;

        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;

        in_valid          <= 1'b1;
        opcode            <= r.op;
        step_total        <= r.total;
        counter_clockwise <= r.ccw;
        step_mode         <= r.mode;
        speed_rpm         <= r.rpm;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);

        was_moving = moving;
        predicted  = advance_sequencer(r);
        expected_coils.push_back(typed ? want : predicted);
        accepted_count++;
        if (r.op != OP_RESERVED && !(r.op == sps_pkg::OP_TICK && !was_moving))
            counted_requests++;
    endtask

    task automatic send_plain(input motor_req_t r);
        send_request(r, 1'b0, '0);
    endtask

    task automatic send_ticks(input int n);
        motor_req_t r;
        for (int i = 0; i < n; i++)
        begin
            r    = random_request();
            r.op = sps_pkg::OP_TICK;
            send_plain(r);
        end
    endtask

    // Hold off the sender until every pending result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_coils.size() != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    // Receiver: stall on a changing pattern
    initial
    begin
        int stall_mode;
        int span;
        int cnt;

        out_ready <= 1'b1;
        cnt = 0;
        forever
        begin
            stall_mode = $urandom_range(0, 3);
            span       = $urandom_range(20, 80);
            for (int i = 0; i < span; i++)
            begin
                @(posedge clk);
                cnt++;
                case (stall_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom);
                    2:       out_ready <= ((cnt % 4) == 0);
                    default: out_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Compare each taken result with the oldest expectation
    always @(posedge clk)
    begin
        coil_state_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (expected_coils.size() == 0)
                report_mismatch("result with nothing pending", {coils, busy_res, phase}, 0);
            else
            begin
                want = expected_coils.pop_front();
                if (coils !== want.coils)
                    report_mismatch("coils", coils, want.coils);
                if (busy_res !== want.busy)
                    report_mismatch("busy_res", busy_res, want.busy);
                if (phase !== want.phase)
                    report_mismatch("phase", phase, want.phase);
            end
        end
    end

    // Stimulus
    initial
    begin
        motor_req_t r;
        int         kind;
        int         steps;
        int         n;
        logic       pressure_done;

        in_valid          <= 1'b0;
        opcode            <= sps_pkg::OP_TICK;
        step_total        <= '0;
        counter_clockwise <= 1'b0;
        step_mode         <= sps_pkg::MODE_HALF;
        speed_rpm         <= '0;
        error_count      = 0;
        accepted_count   = 0;
        counted_requests = 0;
        start_count      = 0;
        stop_count       = 0;
        tick_count       = 0;
        advance_count    = 0;
        completed_moves  = 0;
        burst_left       = 0;
        pressure_done    = 1'b0;
        pos_idx          = '0;
        period_ticks     = '0;
        cur_mode         = sps_pkg::MODE_HALF;
        upward           = 1'b0;
        halt_motion();

        // Idle checks right after reset
        directed_rows.push_back(make_row(
            make_request(sps_pkg::OP_TICK, 20'h0, 1'b0, sps_pkg::MODE_HALF, 10'h0),
            1'b1, 4'h0, 1'b0, 3'd0));
        directed_rows.push_back(make_row(
            make_request(sps_pkg::OP_STOP, 20'h0, 1'b0, sps_pkg::MODE_HALF, 10'h0),
            1'b1, 4'h0, 1'b0, 3'd0));
        directed_rows.push_back(make_row(
            make_request(OP_RESERVED, 20'hFFFFF, 1'b1, MODE_UNKNOWN, 10'h3FF),
            1'b1, 4'h0, 1'b0, 3'd0));
        // Start, ignore the reserved opcode, then restart while running
        directed_rows.push_back(make_row(
            make_request(sps_pkg::OP_START, 20'd5, 1'b1, sps_pkg::MODE_HALF, 10'd1023),
            1'b1, 4'h1, 1'b1, 3'd0));
        directed_rows.push_back(make_row(
            make_request(OP_RESERVED, 20'h0, 1'b0, sps_pkg::MODE_FULL, 10'h0),
            1'b1, 4'h1, 1'b1, 3'd0));
        directed_rows.push_back(make_row(
            make_request(sps_pkg::OP_TICK, 20'h0, 1'b0, sps_pkg::MODE_HALF, 10'h0),
            1'b0, 4'h0, 1'b0, 3'd0));
        directed_rows.push_back(make_row(
            make_request(sps_pkg::OP_START, 20'd3, 1'b0, sps_pkg::MODE_FULL, 10'd512),
            1'b1, 4'h9, 1'b1, 3'd3));
        // Stop running, then stop and tick while idle: phase holds
        directed_rows.push_back(make_row(
            make_request(sps_pkg::OP_STOP, 20'h0, 1'b0, sps_pkg::MODE_HALF, 10'h0),
            1'b1, 4'h0, 1'b0, 3'd3));
        directed_rows.push_back(make_row(
            make_request(sps_pkg::OP_STOP, 20'h0, 1'b0, sps_pkg::MODE_HALF, 10'h0),
            1'b1, 4'h0, 1'b0, 3'd3));
        directed_rows.push_back(make_row(
            make_request(sps_pkg::OP_TICK, 20'h0, 1'b0, sps_pkg::MODE_HALF, 10'h0),
            1'b1, 4'h0, 1'b0, 3'd3));
        // Slowest speeds, wave mode both ways
        directed_rows.push_back(make_row(
            make_request(sps_pkg::OP_START, 20'd1, 1'b1, sps_pkg::MODE_WAVE, 10'd0),
            1'b1, 4'h1, 1'b1, 3'd0));
        directed_rows.push_back(make_row(
            make_request(sps_pkg::OP_START, 20'd2, 1'b0, sps_pkg::MODE_WAVE, 10'd1),
            1'b1, 4'h8, 1'b1, 3'd3));
        // Unknown mode runs as half step; largest step total
        directed_rows.push_back(make_row(
            make_request(sps_pkg::OP_START, 20'hFFFFF, 1'b0, MODE_UNKNOWN, 10'h3FF),
            1'b1, 4'h9, 1'b1, 3'd7));
        for (int i = 0; i < 3; i++)
            directed_rows.push_back(make_row(
                make_request(sps_pkg::OP_TICK, 20'h0, 1'b0, sps_pkg::MODE_HALF, 10'h0),
                1'b0, 4'h0, 1'b0, 3'd0));
        // Zero step total: idle, coils low, phase at the starting index
        directed_rows.push_back(make_row(
            make_request(sps_pkg::OP_START, 20'd0, 1'b0, sps_pkg::MODE_HALF, 10'd300),
            1'b1, 4'h0, 1'b0, 3'd7));
        directed_rows.push_back(make_row(
            make_request(sps_pkg::OP_START, 20'd0, 1'b1, sps_pkg::MODE_FULL, 10'd0),
            1'b1, 4'h0, 1'b0, 3'd0));
        directed_rows.push_back(make_row(
            make_request(sps_pkg::OP_START, 20'd1, 1'b1, sps_pkg::MODE_HALF, 10'd1023),
            1'b1, 4'h1, 1'b1, 3'd0));
        directed_rows.push_back(make_row(
            make_request(sps_pkg::OP_STOP, 20'h0, 1'b0, sps_pkg::MODE_HALF, 10'h0),
            1'b1, 4'h0, 1'b0, 3'd0));
        // Top-bit and alternating bit patterns in the count and speed fields
        directed_rows.push_back(make_row(
            make_request(sps_pkg::OP_START, 20'h80000, 1'b1, sps_pkg::MODE_FULL, 10'h200),
            1'b1, 4'h3, 1'b1, 3'd0));
        directed_rows.push_back(make_row(
            make_request(sps_pkg::OP_START, 20'h55555, 1'b1, sps_pkg::MODE_WAVE, 10'h155),
            1'b1, 4'h1, 1'b1, 3'd0));
        directed_rows.push_back(make_row(
            make_request(sps_pkg::OP_START, 20'hAAAAA, 1'b0, sps_pkg::MODE_HALF, 10'h2AA),
            1'b1, 4'h9, 1'b1, 3'd7));
        directed_rows.push_back(make_row(
            make_request(sps_pkg::OP_STOP, 20'h0, 1'b0, sps_pkg::MODE_HALF, 10'h0),
            1'b1, 4'h0, 1'b0, 3'd7));

        // Wait out reset
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        drain_results();
        counted_requests = 0;

        // Random part: mostly complete moves, some noise and cut-short moves
        while (counted_requests < RANDOM_REQUESTS)
        begin
            if (!pressure_done && counted_requests >= PRESSURE_POINT)
            begin
                drain_results();
                pressure_done = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                steps = $urandom_range(1, 12);
                r = make_request(sps_pkg::OP_START, sps_pkg::TOTAL_W'(steps), 1'($urandom),
                                 sps_pkg::MODE_W'($urandom_range(0, 3)),
                                 sps_pkg::RPM_W'($urandom_range(730, 1023)));
                send_plain(r);
                n = steps * int'(period_ticks);
                if ($urandom_range(0, 4) != 0)
                    n = n + $urandom_range(0, 2);
                else
                    n = $urandom_range(1, n);
                send_ticks(n);
                if ($urandom_range(0, 1) == 0)
                begin
                    r    = random_request();
                    r.op = sps_pkg::OP_STOP;
                    send_plain(r);
                end
            end
            else if (kind < 85)
            begin
                // Noise: fully random requests, then settle with a stop
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    send_plain(random_request());
                r    = random_request();
                r.op = sps_pkg::OP_STOP;
                send_plain(r);
            end
            else if (kind < 92)
            begin
                // Idle stops and ticks
                r    = random_request();
                r.op = sps_pkg::OP_STOP;
                send_plain(r);
                send_ticks($urandom_range(1, 4));
            end
            else
            begin
                // Broken move: restart partway through
                r = make_request(sps_pkg::OP_START,
                                 sps_pkg::TOTAL_W'($urandom_range(2, 10)), 1'($urandom),
                                 sps_pkg::MODE_W'($urandom_range(0, 3)),
                                 sps_pkg::RPM_W'($urandom_range(900, 1023)));
                send_plain(r);
                send_ticks($urandom_range(1, 40));
                r.ccw  = ~r.ccw;
                r.mode = sps_pkg::MODE_W'($urandom_range(0, 3));
                send_plain(r);
                send_ticks($urandom_range(1, 60));
            end
        end

        // Let every result come back, then watch for stray ones
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_coils.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d starts, %0d stops, %0d ticks",
                 accepted_count, start_count, stop_count, tick_count);
        $display("Phase advances %0d, moves run to their end %0d, mismatches %0d",
                 advance_count, completed_moves, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
